// ===== design/cdml_pkg.sv =====
// Shared constants, types and helper functions for the CD position converter.
package cdml_pkg;

	// CD timing constants
	localparam int unsigned LEAD_IN_SECTORS    = 150;
	localparam int unsigned FRAMES_PER_SECOND  = 75;
	localparam int unsigned SECONDS_PER_MINUTE = 60;
	localparam int unsigned MAX_ENCODABLE      = 449849;

	// Field widths
	localparam int unsigned SECTOR_IN_W  = 20;
	localparam int unsigned SECTOR_OUT_W = 21;
	localparam int unsigned BCD_W        = 8;
	localparam int unsigned BCD7_W       = 7;
	localparam int unsigned BYTE_VAL_W   = 8;   // decoded byte, up to 165
	localparam int unsigned MS_VAL_W     = 14;  // minutes*60 + seconds, up to 10065
	localparam int unsigned TOTAL_W      = 19;  // sector + lead-in, up to 449999

	// Reciprocal shifts for the constant dividers
	localparam int unsigned DIV_FRAME_SHIFT = 20;
	localparam int unsigned DIV_SEC_SHIFT   = 14;

	// Side data that rides along with the encode path
	typedef struct packed {
		logic                           op;
		logic                           rng;
		logic signed [SECTOR_OUT_W-1:0] sector;
	} side_t;

	// Two BCD nibbles to a binary value; nibbles above nine are taken as they are
	function automatic logic [BYTE_VAL_W-1:0] bcd_value(input logic [BCD_W-1:0] b);
		logic [BYTE_VAL_W-1:0] hi;
		logic [BYTE_VAL_W-1:0] lo;
		hi = BYTE_VAL_W'(b[7:4]);
		lo = BYTE_VAL_W'(b[3:0]);
		return (hi << 3) + (hi << 1) + lo;
	endfunction

	// Binary value below 100 to two BCD nibbles; tens by reciprocal 205/2048
	function automatic logic [BCD_W-1:0] to_bcd(input logic [BYTE_VAL_W-1:0] v);
		logic [15:0] prod;
		logic [3:0]  tens;
		logic [7:0]  units;
		prod  = 16'(v) * 16'd205;
		tens  = prod[14:11];
		units = v - ((8'(tens) << 3) + (8'(tens) << 1));
		return {tens, units[3:0]};
	endfunction

endpackage

// ===== design/cd_msf_lba_converter.sv =====
// Top level of the CD position converter: BCD minute:second:frame <-> sector number.
//
// Requests enter on start with operation and the input fields; busy is always low,
// so a new request is taken in every cycle. Each request gives one result,
// shown for one cycle with done high.
// Throughput is one request per cycle; latency is set by the encode path:
// one input stage, two three-stage constant dividers (by 75 and by 60) and
// one BCD output stage. The decode path (weighted nibbles, *60, *75, -150)
// is shorter and rides alongside to stay in order.
// Operation 0 gives sector_out and zero BCD fields; operation 1 gives BCD
// fields and zero sector_out, with range_error set and zero BCD fields for a
// sector above 99:59:74.
// Reset clears the valid bits, so no done strobe comes out of the flush.
// The receiver cannot stall; results must be taken in the cycle they appear.
module cd_msf_lba_converter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  operation,
	input  logic [cdml_pkg::SECTOR_IN_W-1:0]      sector_in,
	input  logic [cdml_pkg::BCD_W-1:0]            minute_bcd_in,
	input  logic [cdml_pkg::BCD_W-1:0]            second_bcd_in,
	input  logic [cdml_pkg::BCD_W-1:0]            frame_bcd_in,
	output logic                                  done,
	output logic signed [cdml_pkg::SECTOR_OUT_W-1:0] sector_out,
	output logic [cdml_pkg::BCD_W-1:0]            minute_bcd_out,
	output logic [cdml_pkg::BCD7_W-1:0]           second_bcd_out,
	output logic [cdml_pkg::BCD7_W-1:0]           frame_bcd_out,
	output logic                                  range_error
);

	localparam int unsigned SW  = cdml_pkg::SECTOR_OUT_W;
	localparam int unsigned BVW = cdml_pkg::BYTE_VAL_W;
	localparam int unsigned MSW = cdml_pkg::MS_VAL_W;
	localparam int unsigned TW  = cdml_pkg::TOTAL_W;
	localparam int unsigned SQW = TW - $clog2(cdml_pkg::FRAMES_PER_SECOND) + 1;
	localparam int unsigned FRW = $clog2(cdml_pkg::FRAMES_PER_SECOND);
	localparam int unsigned MQW = SQW - $clog2(cdml_pkg::SECONDS_PER_MINUTE) + 1;
	localparam int unsigned SRW = $clog2(cdml_pkg::SECONDS_PER_MINUTE);

	logic accept;
	logic over_max;

	// stage 1
	logic           valid_s1, op_s1, rng_s1;
	logic [BVW-1:0] mval_s1, sval_s1, fval_s1;
	logic [TW-1:0]  total_s1;
	// stage 2
	logic           valid_s2, op_s2, rng_s2;
	logic [MSW-1:0] ms_s2;
	logic [BVW-1:0] fval_s2;
	// stage 3
	logic           valid_s3;
	cdml_pkg::side_t side_s3;
	// stages 4 to 7
	cdml_pkg::side_t side_s4, side_s5, side_s6, side_s7;
	logic [FRW-1:0] frame_s5, frame_s6, frame_s7;
	// divider outputs
	logic           valid_s4, valid_s7;
	logic [SQW-1:0] secs_s4;
	logic [FRW-1:0] frame_s4;
	logic [MQW-1:0] min_s7;
	logic [SRW-1:0] sec_s7;
	// output stage
	logic                     done_s8;
	logic signed [SW-1:0]     sector_s8;
	logic [cdml_pkg::BCD_W-1:0]  min_s8;
	logic [cdml_pkg::BCD7_W-1:0] sec_s8, frm_s8;
	logic                     rng_s8;

	logic [cdml_pkg::BCD_W-1:0] min_bcd, sec_bcd, frm_bcd;

	// pipeline never holds off a request
	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign over_max = sector_in > cdml_pkg::SECTOR_IN_W'(cdml_pkg::MAX_ENCODABLE);

	// valid bits of the top-level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_s8  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_s8  <= valid_s7;
		end
	end

	// stage 1: nibble decode, range check, add lead-in
	always_ff @(posedge clk) begin
		op_s1   <= operation;
		rng_s1  <= operation && over_max;
		mval_s1 <= cdml_pkg::bcd_value(minute_bcd_in);
		sval_s1 <= cdml_pkg::bcd_value(second_bcd_in);
		fval_s1 <= cdml_pkg::bcd_value(frame_bcd_in);
		if (operation && !over_max)
			total_s1 <= TW'(sector_in + cdml_pkg::SECTOR_IN_W'(cdml_pkg::LEAD_IN_SECTORS));
		else
			total_s1 <= '0;
	end

	// stage 2: minutes * 60 + seconds
	always_ff @(posedge clk) begin
		op_s2   <= op_s1;
		rng_s2  <= rng_s1;
		ms_s2   <= MSW'(mval_s1) * MSW'(cdml_pkg::SECONDS_PER_MINUTE) + MSW'(sval_s1);
		fval_s2 <= fval_s1;
	end

	// stage 3: * 75 + frame - lead-in, wraps to 21 bits
	always_ff @(posedge clk) begin
		side_s3.op     <= op_s2;
		side_s3.rng    <= rng_s2;
		side_s3.sector <= signed'(SW'(ms_s2) * SW'(cdml_pkg::FRAMES_PER_SECOND)
			+ SW'(fval_s2) - SW'(cdml_pkg::LEAD_IN_SECTORS));
	end

	// frames per second split, stages 2 to 4
	cdml_cdiv #(
		.DW      (TW),
		.DIVISOR (cdml_pkg::FRAMES_PER_SECOND),
		.SHIFT   (cdml_pkg::DIV_FRAME_SHIFT)
	) u_div_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.dividend  (total_s1),
		.out_valid (valid_s4),
		.quotient  (secs_s4),
		.remainder (frame_s4)
	);

	// seconds per minute split, stages 5 to 7
	cdml_cdiv #(
		.DW      (SQW),
		.DIVISOR (cdml_pkg::SECONDS_PER_MINUTE),
		.SHIFT   (cdml_pkg::DIV_SEC_SHIFT)
	) u_div_sec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.dividend  (secs_s4),
		.out_valid (valid_s7),
		.quotient  (min_s7),
		.remainder (sec_s7)
	);

	// side data delay to line up with the dividers
	always_ff @(posedge clk) begin
		side_s4  <= side_s3;
		side_s5  <= side_s4;
		side_s6  <= side_s5;
		side_s7  <= side_s6;
		frame_s5 <= frame_s4;
		frame_s6 <= frame_s5;
		frame_s7 <= frame_s6;
	end

	// BCD encode of the split parts
	always_comb begin
		min_bcd = cdml_pkg::to_bcd(BVW'(min_s7));
		sec_bcd = cdml_pkg::to_bcd(BVW'(sec_s7));
		frm_bcd = cdml_pkg::to_bcd(BVW'(frame_s7));
	end

	// stage 8: select per operation, zero unused fields
	always_ff @(posedge clk) begin
		rng_s8 <= side_s7.op && side_s7.rng;
		if (side_s7.op)
			sector_s8 <= '0;
		else
			sector_s8 <= side_s7.sector;
		if (side_s7.op && !side_s7.rng) begin
			min_s8 <= min_bcd;
			sec_s8 <= sec_bcd[cdml_pkg::BCD7_W-1:0];
			frm_s8 <= frm_bcd[cdml_pkg::BCD7_W-1:0];
		end else begin
			min_s8 <= '0;
			sec_s8 <= '0;
			frm_s8 <= '0;
		end
	end

	assign done           = done_s8;
	assign sector_out     = sector_s8;
	assign minute_bcd_out = min_s8;
	assign second_bcd_out = sec_s8;
	assign frame_bcd_out  = frm_s8;
	assign range_error    = rng_s8;

	a_range_zero_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		done && range_error |-> (minute_bcd_out == '0 && second_bcd_out == '0
			&& frame_bcd_out == '0 && sector_out == '0))
		else $error("range error with nonzero fields");

	a_decode_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && sector_out != '0 |-> (!range_error && minute_bcd_out == '0
			&& second_bcd_out == '0 && frame_bcd_out == '0))
		else $error("decode result carries encode fields");

	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (minute_bcd_out[3:0] <= 4'd9 && minute_bcd_out[7:4] <= 4'd9
			&& second_bcd_out[3:0] <= 4'd9 && frame_bcd_out[3:0] <= 4'd9))
		else $error("BCD output holds a digit above nine");

endmodule

// ===== design/cdml_cdiv.sv =====
// Three-stage pipelined divider by a constant: reciprocal multiply and one correction.
module cdml_cdiv #(
	parameter int unsigned DW      = cdml_pkg::TOTAL_W,
	parameter int unsigned DIVISOR = cdml_pkg::FRAMES_PER_SECOND,
	// SHIFT must keep the estimate within one of the true quotient over DW bits
	parameter int unsigned SHIFT   = cdml_pkg::DIV_FRAME_SHIFT,
	parameter int unsigned QW      = DW - $clog2(DIVISOR) + 1,
	parameter int unsigned RW      = $clog2(DIVISOR)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] dividend,
	output logic          out_valid,
	output logic [QW-1:0] quotient,
	output logic [RW-1:0] remainder
);

	localparam int unsigned RECIP = (2 ** SHIFT) / DIVISOR;
	localparam int unsigned MW    = $clog2(RECIP + 1);
	localparam int unsigned PW    = DW + MW;

	logic          valid_s1, valid_s2, valid_s3;
	logic [PW-1:0] prod_s1;
	logic [DW-1:0] dvd_s1;
	logic [QW-1:0] qest_s2;
	logic [RW:0]   rest_s2;
	logic [QW-1:0] quot_s3;
	logic [RW-1:0] rem_s3;

	logic [QW-1:0] qest;
	logic [DW-1:0] qmul;

	// estimate quotient and remainder
	always_comb begin
		qest = QW'(prod_s1 >> SHIFT);
		qmul = DW'(qest) * DW'(DIVISOR);
	end

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// data stages
	always_ff @(posedge clk) begin
		prod_s1 <= PW'(dividend) * PW'(RECIP);
		dvd_s1  <= dividend;
		qest_s2 <= qest;
		rest_s2 <= (RW + 1)'(dvd_s1 - qmul);
		// estimate may be one short
		if (rest_s2 >= (RW + 1)'(DIVISOR)) begin
			quot_s3 <= qest_s2 + QW'(1);
			rem_s3  <= RW'(rest_s2 - (RW + 1)'(DIVISOR));
		end else begin
			quot_s3 <= qest_s2;
			rem_s3  <= RW'(rest_s2);
		end
	end

	assign out_valid = valid_s3;
	assign quotient  = quot_s3;
	assign remainder = rem_s3;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(remainder) < 32'(DIVISOR)))
		else $error("divider remainder not below divisor");

	a_quot_exact: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((32'(quotient) * 32'(DIVISOR) + 32'(remainder))
			== 32'($past(dividend, 3))))
		else $error("divider result does not rebuild the dividend");

	a_valid_delay: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(in_valid, 3))
		else $error("divider output valid without a request three cycles earlier");

endmodule
